// ----- hdl/positional_insert_delete_array_top_assert.svh -----
// Assertion macros for the positional insert/delete array.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_TOP_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define PIDA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define PIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pida_pkg.sv -----
// Shared types and constants for the positional insert/delete array.
// No dependencies; used by pida_ctrl, pida_dp and the top level.
package pida_pkg;

    localparam int CAPACITY  = 64;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KIND_W    = 2;
    localparam int POS_W     = 7;
    localparam int VAL_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;
    localparam int S_BITS    = KIND_W + POS_W + VAL_W;
    localparam int M_BITS    = STAT_W + CNT_OUT_W + VAL_W;
    localparam int TDATA_W   = ((S_BITS > M_BITS ? S_BITS : M_BITS) + 7) / 8 * 8;
    localparam int S_PAD_W   = TDATA_W - S_BITS;
    localparam int M_PAD_W   = TDATA_W - M_BITS;
    localparam int CMP_W     = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the incoming word
        logic judge;     // latch the result status
        logic mv_start;  // set the shift pointer to its first entry
        logic mv_read;   // read one entry to be moved, step the pointer
        logic put;       // write the operand value at the target position
        logic rd_pos;    // read the entry at the target position
        logic cnt_inc;
        logic cnt_dec;
        logic finish;    // load the output register
    } pida_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        kind_t kind;
        logic  pos_bad;
        logic  full;
        logic  no_moves;
        logic  last_move;
        logic  out_free;
    } pida_stat_t;

endpackage

// ----- hdl/positional_insert_delete_array_top.sv -----
// Positional insert/delete array, top level. An insert moves count - position entries
// (none when appending), a delete count - position - 1 (none when removing the last
// entry); update, read and rejected items move none. One item is in work at a time;
// the next word is taken the cycle after the result is loaded. Shifts move one entry
// per cycle through the memory port. Reset (aresetn low, synchronous) empties the
// store and drops any pending result.
module positional_insert_delete_array_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata, low bit up: kind[1:0], position[8:2], value[40:9], zero pad
    input  logic [pida_pkg::TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata, low bit up: status[1:0], count[8:2], read_value[40:9], zero pad
    output logic [pida_pkg::TDATA_W-1:0] m_tdata
);
    import pida_pkg::*;

    pida_cmd_t  cmd;
    pida_stat_t st;

    // Sequencer: accepts a word only in its idle state, then walks the
    // check / shift / write / read steps and loads the output register.
    pida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath: element memory with one write and one registered read port.
    // During a shift, each cycle reads the next entry and writes the one
    // read in the previous cycle to its neighbor slot. The output register lets a
    // new word be taken while the previous result waits for m_tready.
    pida_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

`include "positional_insert_delete_array_top_assert.svh"

    // Hold one item at a time: a word accepted means the port closes next cycle.
    `PIDA_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready, "second word taken while busy")
    // Reported count never exceeds the capacity.
    `PIDA_ASSERT_IMP(a_count_cap, m_tvalid, m_tdata[STAT_W +: CNT_OUT_W] <= CNT_OUT_W'(CAPACITY), "count above capacity")
    // A full status only goes out with a full store.
    `PIDA_ASSERT_IMP(a_full_flag, m_tvalid && (m_tdata[STAT_W-1:0] == ST_FULL), m_tdata[STAT_W +: CNT_OUT_W] == CNT_OUT_W'(CAPACITY), "full status with room left")

endmodule

// ----- hdl/pida_dp.sv -----
// Datapath of the positional insert/delete array: element memory, count,
// shift pointer and output register. Depends on pida_pkg.
module pida_dp (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [pida_pkg::TDATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [pida_pkg::TDATA_W-1:0] m_tdata,
    input  pida_pkg::pida_cmd_t          cmd,
    output pida_pkg::pida_stat_t         st
);
    import pida_pkg::*;

    logic [VAL_W-1:0]   mem [CAPACITY];

    kind_t              kind_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [VAL_W-1:0]   value_reg;
    status_t            status_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [ADDR_W-1:0]  wa_reg;
    logic               pend_reg;
    logic [VAL_W-1:0]   rdata_reg;
    logic               m_tvalid_reg;
    logic [TDATA_W-1:0] m_tdata_reg;

    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   ptr_ext;
    logic               is_insert;
    logic               pos_bad;
    logic               full;
    logic [ADDR_W-1:0]  pos_addr;
    logic [ADDR_W-1:0]  ptr_start;
    logic [ADDR_W-1:0]  rd_addr;
    status_t            status_calc;
    logic [VAL_W-1:0]   read_value;

    assign pos_ext   = CMP_W'(pos_reg);
    assign cnt_ext   = CMP_W'(count_reg);
    assign ptr_ext   = CMP_W'(ptr_reg);
    assign is_insert = (kind_reg == KIND_INSERT);
    assign pos_bad   = is_insert ? (pos_ext > cnt_ext) : (pos_ext >= cnt_ext);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_addr  = ADDR_W'(pos_reg);
    // Insert moves entries from the top down, delete from just above the hole up.
    assign ptr_start = is_insert ? ADDR_W'(count_reg - CNT_W'(1))
                                 : ADDR_W'(pos_reg + POS_W'(1));
    assign rd_addr   = cmd.mv_read ? ptr_reg : pos_addr;

    always_comb begin
        if (pos_bad) begin
            status_calc = ST_RANGE;
        end else if (is_insert && full) begin
            status_calc = ST_FULL;
        end else begin
            status_calc = ST_DONE;
        end
    end

    assign read_value = (kind_reg == KIND_READ && status_reg == ST_DONE) ? rdata_reg : '0;

    assign st.kind      = kind_reg;
    assign st.pos_bad   = pos_bad;
    assign st.full      = full;
    assign st.no_moves  = is_insert ? (pos_ext == cnt_ext)
                                    : (pos_ext + CMP_W'(1) == cnt_ext);
    assign st.last_move = is_insert ? (ptr_ext == pos_ext)
                                    : (ptr_ext + CMP_W'(1) == cnt_ext);
    assign st.out_free  = !m_tvalid_reg || m_tready;

    // Element memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (pend_reg) begin
            mem[wa_reg] <= rdata_reg;
        end else if (cmd.put) begin
            mem[pos_addr] <= value_reg;
        end
        if (cmd.mv_read || cmd.rd_pos) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.mv_read;
            if (cmd.cnt_inc) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (cmd.cnt_dec) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= kind_t'(s_tdata[KIND_W-1:0]);
            pos_reg   <= s_tdata[KIND_W +: POS_W];
            value_reg <= s_tdata[KIND_W+POS_W +: VAL_W];
        end
        if (cmd.judge) begin
            status_reg <= status_calc;
        end
        if (cmd.mv_start) begin
            ptr_reg <= ptr_start;
        end else if (cmd.mv_read) begin
            ptr_reg <= is_insert ? ptr_reg - ADDR_W'(1) : ptr_reg + ADDR_W'(1);
            wa_reg  <= is_insert ? ptr_reg + ADDR_W'(1) : ptr_reg - ADDR_W'(1);
        end
        if (cmd.finish) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, read_value, CNT_OUT_W'(count_reg), status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- hdl/pida_ctrl.sv -----
// Controller of the positional insert/delete array: one-hot sequencer that
// drives the datapath commands. Depends on pida_pkg.
module pida_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pida_pkg::pida_stat_t st,
    output pida_pkg::pida_cmd_t  cmd
);
    import pida_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_MOVE   = 7'b0000100,
        S_DRAIN  = 7'b0001000,
        S_PUT    = 7'b0010000,
        S_RDPOS  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.judge = 1'b1;
                if (st.pos_bad || (st.kind == KIND_INSERT && st.full)) begin
                    state_next = S_FINISH;
                end else begin
                    unique case (st.kind)
                        KIND_INSERT: begin
                            if (st.no_moves) begin
                                state_next = S_PUT;
                            end else begin
                                cmd.mv_start = 1'b1;
                                state_next   = S_MOVE;
                            end
                        end
                        KIND_DELETE: begin
                            if (st.no_moves) begin
                                cmd.cnt_dec = 1'b1;
                                state_next  = S_FINISH;
                            end else begin
                                cmd.mv_start = 1'b1;
                                state_next   = S_MOVE;
                            end
                        end
                        KIND_UPDATE: state_next = S_PUT;
                        KIND_READ:   state_next = S_RDPOS;
                        default:     state_next = S_FINISH;
                    endcase
                end
            end
            S_MOVE: begin
                cmd.mv_read = 1'b1;
                if (st.last_move) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (st.kind == KIND_INSERT) begin
                    state_next = S_PUT;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_PUT: begin
                cmd.put     = 1'b1;
                cmd.cnt_inc = (st.kind == KIND_INSERT);
                state_next  = S_FINISH;
            end
            S_RDPOS: begin
                cmd.rd_pos = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH: begin
                if (st.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
